@@ hw/rtl/rrt_pkg.sv @@
// shared types and constants for the registration reply tracker
// no dependencies
package rrt_pkg;

   localparam int PendDepth = 8;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_REPLY  = 2'd1,
      MODE_TICK   = 2'd2,
      MODE_UNUSED = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      OUT_NO_MATCH = 4'd0,
      OUT_BAD_CSUM = 4'd1,
      OUT_ID_MISS  = 4'd2,
      OUT_FOREIGN  = 4'd3,
      OUT_HOME     = 4'd4,
      OUT_DENIED   = 4'd5,
      OUT_INSERTED = 4'd6,
      OUT_FULL     = 4'd7,
      OUT_TICK     = 4'd8
   } outcome_type;

   localparam logic CsrHomeAgent = 1'b0;
   localparam logic CsrThreshold = 1'b1;

   localparam logic [15:0] ThresholdReset = 16'd3;
   localparam logic [7:0]  CodeAcceptMax  = 8'd1;

   typedef struct packed {
      logic [31:0] address;
      logic [15:0] port;
      logic [31:0] ident;
      logic [15:0] requested;
      logic [15:0] remaining;
   } entry_type;

   typedef struct packed {
      logic compare;
      logic insert;
      logic erase;
   } cell_ctrl_type;

endpackage

@@ hw/rtl/rrt_cell.sv @@
// one pending-request slot of the tracker row
// depends on rrt_pkg
module rrt_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  rrt_pkg::cell_ctrl_type ctrl,
   input  logic [31:0]           key_address,
   input  logic [15:0]           key_port,
   input  rrt_pkg::entry_type    new_entry,
   input  logic                  prev_valid,
   input  rrt_pkg::entry_type    next_entry,
   input  logic                  next_valid,
   input  logic                  found_in,
   output logic                  found_out,
   input  rrt_pkg::entry_type    pick_in,
   output rrt_pkg::entry_type    pick_out,
   output rrt_pkg::entry_type    entry_out,
   output logic                  valid_out
);
   import rrt_pkg::*;

   entry_type entry_ff;
   logic      valid_ff;
   logic      match_ff;
   logic      hit;
   logic      shift;

   assign hit       = match_ff & ~found_in;
   assign found_out = found_in | match_ff;
   assign shift     = ctrl.erase & found_out;
   assign pick_out  = pick_in | (hit ? entry_ff : '0);
   assign entry_out = entry_ff;
   assign valid_out = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         if (ctrl.compare) begin
            match_ff <= valid_ff && (entry_ff.address == key_address) &&
                        (entry_ff.port == key_port);
         end
         if (shift) begin
            valid_ff <= next_valid;
         end else if (ctrl.insert && !valid_ff && prev_valid) begin
            valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         entry_ff <= next_entry;
      end else if (ctrl.insert && !valid_ff && prev_valid) begin
         entry_ff <= new_entry;
      end
   end

endmodule

@@ hw/rtl/rrt_csum.sv @@
// udp pseudo-header checksum: registered partial sum, then end-around fold
// depends on rrt_pkg
module rrt_csum (
   input  logic        clock,
   input  logic        load,
   input  logic [31:0] source_address,
   input  logic [31:0] dest_address,
   input  logic [15:0] udp_length,
   input  logic [15:0] segment_checksum,
   output logic        csum_ok
);
   import rrt_pkg::*;

   logic [15:0] seg_inv;
   logic [18:0] sum_in;
   logic [18:0] sum_ff;
   logic [16:0] fold1;
   logic [15:0] fold2;

   assign seg_inv = ~segment_checksum;
   assign sum_in  = 19'(seg_inv) + 19'(source_address[31:16]) +
                    19'(source_address[15:0]) + 19'(dest_address[31:16]) +
                    19'(dest_address[15:0]) + 19'(udp_length) + 19'd17;

   always_ff @(posedge clock) begin
      if (load) begin
         sum_ff <= sum_in;
      end
   end

   assign fold1   = 17'(sum_ff[15:0]) + 17'(sum_ff[18:16]);
   assign fold2   = fold1[15:0] + 16'(fold1[16]);
   assign csum_ok = (fold2 == 16'hffff);

endmodule

@@ hw/rtl/registration_reply_tracker_unit.sv @@
// registration reply tracker top level: control, row of pending-request cells
// depends on rrt_pkg, rrt_cell, rrt_csum
//
// use: items enter on the req_ channel (valid/ready). mode 0 stores a pending
// request in the next free slot, mode 1 matches a registration reply against
// the oldest pending slot with the same agent address and port, mode 2 is the
// one-second lifetime tick. every item gives exactly one word on the rsp_
// channel with the outcome and the link state after the item.
// a word is accepted, the cell row compares it and the checksum sum
// is registered in the next cycle; the decision is taken and the result word
// is registered in the decide step once the output register is free.
// the next item is accepted only after the compare and decide passes through
// the cell row (erase shifts all later slots up in the decide cycle).
// req_ready is high only between items. if rsp_ready is low the result word
// holds; a finished item waits in the decide step until the output register
// frees, and the next item may be accepted while a word is waiting.
// reset clears all slots, the link state and the timer. csr_ writes take effect
// at once; the user must make them only while the block is idle (not enforced).
module registration_reply_tracker_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_source_address,
   input  logic [31:0] req_dest_address,
   input  logic [15:0] req_dest_port,
   input  logic [15:0] req_udp_length,
   input  logic [15:0] req_segment_checksum,
   input  logic [15:0] req_checksum_field,
   input  logic [31:0] req_ident,
   input  logic [7:0]  req_reply_code,
   input  logic [15:0] req_granted_lifetime,
   input  logic [15:0] req_requested_lifetime,
   input  logic [15:0] req_remaining_lifetime,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_outcome,
   output logic        rsp_connected,
   output logic [31:0] rsp_foreign_agent,
   output logic [15:0] rsp_lifetime_left,
   output logic        rsp_rereg_trigger,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [31:0] csr_write_data
);
   import rrt_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MATCH,
      S_DECIDE
   } state_type;

   state_type     state_ff;
   logic [1:0]    mode_ff;
   logic [31:0]   src_ff;
   logic [31:0]   dst_ff;
   logic [15:0]   port_ff;
   logic [15:0]   ulen_ff;
   logic [15:0]   seg_ff;
   logic [15:0]   csf_ff;
   logic [31:0]   ident_ff;
   logic [7:0]    code_ff;
   logic [15:0]   granted_ff;
   logic [15:0]   requested_ff;
   logic [15:0]   remaining_ff;

   logic [31:0]   home_ff;
   logic [15:0]   thresh_ff;
   logic          link_ff;
   logic [31:0]   agent_ff;
   logic [15:0]   life_ff;
   logic          ticking_ff;

   logic          rsp_valid_ff;
   outcome_type   rsp_outcome_ff;
   logic          rsp_connected_ff;
   logic [31:0]   rsp_agent_ff;
   logic [15:0]   rsp_life_ff;
   logic          rsp_trig_ff;

   logic          link_in;
   logic [31:0]   agent_in;
   logic [15:0]   life_in;
   logic          ticking_in;
   outcome_type   outcome_in;
   logic          trig_in;
   logic          insert_in;
   logic          erase_in;
   logic [15:0]   life_dec;
   logic [15:0]   grant_cut;

   logic          out_free;
   logic          fire;
   logic          csum_ok;
   cell_ctrl_type ctrl;
   entry_type     new_entry;
   entry_type     picked;
   logic          hit_any;
   logic          full;

   entry_type     entry_row [0:PendDepth];
   logic          valid_row [0:PendDepth];
   logic          found_row [0:PendDepth];
   entry_type     pick_row  [0:PendDepth];

   assign req_ready = (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = (state_ff == S_DECIDE) && out_free;

   assign new_entry.address   = src_ff;
   assign new_entry.port      = port_ff;
   assign new_entry.ident     = ident_ff;
   assign new_entry.requested = requested_ff;
   assign new_entry.remaining = remaining_ff;

   assign ctrl.compare = (state_ff == S_MATCH);
   assign ctrl.insert  = fire && insert_in;
   assign ctrl.erase   = fire && erase_in;

   assign entry_row[PendDepth] = '0;
   assign valid_row[PendDepth] = 1'b0;
   assign found_row[0]         = 1'b0;
   assign pick_row[0]          = '0;

   for (genvar i = 0; i < PendDepth; i++) begin : g_cell
      logic prev_valid;
      if (i == 0) begin : g_first
         assign prev_valid = 1'b1;
      end else begin : g_rest
         assign prev_valid = valid_row[i-1];
      end
      rrt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .key_address(src_ff),
         .key_port   (port_ff),
         .new_entry  (new_entry),
         .prev_valid (prev_valid),
         .next_entry (entry_row[i+1]),
         .next_valid (valid_row[i+1]),
         .found_in   (found_row[i]),
         .found_out  (found_row[i+1]),
         .pick_in    (pick_row[i]),
         .pick_out   (pick_row[i+1]),
         .entry_out  (entry_row[i]),
         .valid_out  (valid_row[i])
      );
   end

   assign hit_any = found_row[PendDepth];
   assign picked  = pick_row[PendDepth];
   assign full    = valid_row[PendDepth-1];

   rrt_csum u_csum (
      .clock           (clock),
      .load            (ctrl.compare),
      .source_address  (src_ff),
      .dest_address    (dst_ff),
      .udp_length      (ulen_ff),
      .segment_checksum(seg_ff),
      .csum_ok         (csum_ok)
   );

   assign life_dec  = life_ff - 16'd1;
   assign grant_cut = picked.requested - granted_ff;

   always_comb begin
      link_in    = link_ff;
      agent_in   = agent_ff;
      life_in    = life_ff;
      ticking_in = ticking_ff;
      outcome_in = OUT_NO_MATCH;
      trig_in    = 1'b0;
      insert_in  = 1'b0;
      erase_in   = 1'b0;
      unique case (mode_type'(mode_ff))
         MODE_INSERT: begin
            if (full) begin
               outcome_in = OUT_FULL;
            end else begin
               insert_in  = 1'b1;
               outcome_in = OUT_INSERTED;
            end
         end
         MODE_REPLY: begin
            priority if (!hit_any) begin
               outcome_in = OUT_NO_MATCH;
            end else if (!csum_ok && (csf_ff != 16'd0)) begin
               erase_in   = 1'b1;
               outcome_in = OUT_BAD_CSUM;
            end else if (picked.ident != ident_ff) begin
               outcome_in = OUT_ID_MISS;
            end else if (code_ff <= CodeAcceptMax) begin
               erase_in = 1'b1;
               if (src_ff != home_ff) begin
                  link_in    = 1'b1;
                  agent_in   = picked.address;
                  life_in    = picked.remaining - grant_cut;
                  ticking_in = 1'b1;
                  outcome_in = OUT_FOREIGN;
               end else begin
                  ticking_in = 1'b0;
                  outcome_in = OUT_HOME;
               end
            end else begin
               erase_in   = 1'b1;
               outcome_in = OUT_DENIED;
            end
         end
         MODE_TICK: begin
            outcome_in = OUT_TICK;
            if (ticking_ff && (life_ff != 16'd0)) begin
               life_in = life_dec;
               trig_in = (life_dec == thresh_ff);
               if (life_dec == 16'd0) begin
                  link_in = 1'b0;
               end
            end
         end
         default: begin
            outcome_in = OUT_NO_MATCH;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         home_ff      <= '0;
         thresh_ff    <= ThresholdReset;
         link_ff      <= 1'b0;
         agent_ff     <= '0;
         life_ff      <= '0;
         ticking_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CsrHomeAgent: home_ff   <= csr_write_data;
               CsrThreshold: thresh_ff <= csr_write_data[15:0];
               default:      home_ff   <= home_ff;
            endcase
         end
         if (rsp_valid_ff && rsp_ready && !fire) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_MATCH;
               end
            end
            S_MATCH: begin
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               if (out_free) begin
                  state_ff     <= S_IDLE;
                  link_ff      <= link_in;
                  agent_ff     <= agent_in;
                  life_ff      <= life_in;
                  ticking_ff   <= ticking_in;
                  rsp_valid_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         mode_ff      <= req_mode;
         src_ff       <= req_source_address;
         dst_ff       <= req_dest_address;
         port_ff      <= req_dest_port;
         ulen_ff      <= req_udp_length;
         seg_ff       <= req_segment_checksum;
         csf_ff       <= req_checksum_field;
         ident_ff     <= req_ident;
         code_ff      <= req_reply_code;
         granted_ff   <= req_granted_lifetime;
         requested_ff <= req_requested_lifetime;
         remaining_ff <= req_remaining_lifetime;
      end
      if (fire) begin
         rsp_outcome_ff   <= outcome_in;
         rsp_connected_ff <= link_in;
         rsp_agent_ff     <= agent_in;
         rsp_life_ff      <= life_in;
         rsp_trig_ff      <= trig_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_outcome       = rsp_outcome_ff;
   assign rsp_connected     = rsp_connected_ff;
   assign rsp_foreign_agent = rsp_agent_ff;
   assign rsp_lifetime_left = rsp_life_ff;
   assign rsp_rereg_trigger = rsp_trig_ff;

endmodule

@@ hw/rtl/rrt_checker.sv @@
// port-level checks for the registration reply tracker, bound to the top level
// depends on rrt_pkg and registration_reply_tracker_unit
module rrt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_outcome,
   input logic        rsp_connected,
   input logic [31:0] rsp_foreign_agent,
   input logic [15:0] rsp_lifetime_left,
   input logic        rsp_rereg_trigger
);
   import rrt_pkg::*;

   a_trig_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rereg_trigger |-> rsp_outcome == OUT_TICK)
      else $error("rereg trigger on a non-tick word");

   a_outcome_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_outcome <= OUT_TICK)
      else $error("outcome code out of range");

   a_foreign_connects: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome == OUT_FOREIGN |-> rsp_connected)
      else $error("foreign accept without connected flag");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_outcome) &&
      $stable(rsp_foreign_agent) && $stable(rsp_lifetime_left))
      else $error("result word changed while stalled");

endmodule

bind registration_reply_tracker_unit rrt_checker u_rrt_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_outcome      (rsp_outcome),
   .rsp_connected    (rsp_connected),
   .rsp_foreign_agent(rsp_foreign_agent),
   .rsp_lifetime_left(rsp_lifetime_left),
   .rsp_rereg_trigger(rsp_rereg_trigger)
);

@@ tb/tb.sv @@
// testbench for registration_reply_tracker_unit: directed and random request words,
// checked word by word against an in-bench prediction of the tracker
// depends on rrt_pkg and the registration_reply_tracker_unit rtl
`timescale 1ns / 100ps

module tb;
   import rrt_pkg::*;

   typedef struct packed {
      mode_type    mode;
      logic [31:0] source_address;
      logic [31:0] dest_address;
      logic [15:0] dest_port;
      logic [15:0] udp_length;
      logic [15:0] segment_checksum;
      logic [15:0] checksum_field;
      logic [31:0] ident;
      logic [7:0]  reply_code;
      logic [15:0] granted_lifetime;
      logic [15:0] requested_lifetime;
      logic [15:0] remaining_lifetime;
   } request_word_type;

   typedef struct packed {
      outcome_type outcome;
      logic        connected;
      logic [31:0] agent;
      logic [15:0] life;
      logic        trigger;
   } result_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_outcome;
   logic        rsp_connected;
   logic [31:0] rsp_foreign_agent;
   logic [15:0] rsp_lifetime_left;
   logic        rsp_rereg_trigger;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = CsrHomeAgent;
   logic [31:0] csr_write_data = '0;

   request_word_type drive_word = '0;

   request_word_type request_backlog [$];
   entry_type        booked_requests [$];
   result_word_type  expected_results [$];

   // tracker state as predicted
   entry_type               held_entry [PendDepth];
   logic [PendDepth-1:0]    held_valid = '0;
   logic                    link_up_now = 1'b0;
   logic [31:0]             agent_now = '0;
   logic [15:0]             life_now = '0;
   logic                    timer_running = 1'b0;
   logic [31:0]             home_cfg = '0;
   logic [15:0]             threshold_cfg = ThresholdReset;

   bit in_fire = 1'b0;
   bit long_hold_go = 1'b0;
   bit long_hold_on = 1'b0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int mismatch_count = 0;
   int requests_taken = 0;
   int replies_checked = 0;
   int trigger_seen = 0;
   int outcome_seen [0:8];

   registration_reply_tracker_unit uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_mode               (drive_word.mode),
      .req_source_address     (drive_word.source_address),
      .req_dest_address       (drive_word.dest_address),
      .req_dest_port          (drive_word.dest_port),
      .req_udp_length         (drive_word.udp_length),
      .req_segment_checksum   (drive_word.segment_checksum),
      .req_checksum_field     (drive_word.checksum_field),
      .req_ident              (drive_word.ident),
      .req_reply_code         (drive_word.reply_code),
      .req_granted_lifetime   (drive_word.granted_lifetime),
      .req_requested_lifetime (drive_word.requested_lifetime),
      .req_remaining_lifetime (drive_word.remaining_lifetime),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_outcome            (rsp_outcome),
      .rsp_connected          (rsp_connected),
      .rsp_foreign_agent      (rsp_foreign_agent),
      .rsp_lifetime_left      (rsp_lifetime_left),
      .rsp_rereg_trigger      (rsp_rereg_trigger),
      .csr_write_enable       (csr_write_enable),
      .csr_index              (csr_index),
      .csr_write_data         (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // folded one's-complement sum of pseudo-header and segment
   function automatic logic [15:0] ones_sum(request_word_type w);
      logic [31:0] acc;
      acc = {16'd0, ~w.segment_checksum} + 32'(w.source_address[31:16])
            + 32'(w.source_address[15:0]) + 32'(w.dest_address[31:16])
            + 32'(w.dest_address[15:0]) + 32'd17 + 32'(w.udp_length);
      while (acc[31:16] != 16'd0)
         acc = 32'(acc[15:0]) + 32'(acc[31:16]);
      return acc[15:0];
   endfunction

   function automatic void drop_entry(int k);
      int i;
      for (i = k; i < PendDepth - 1; i++) begin
         held_entry[i] = held_entry[i + 1];
         held_valid[i] = held_valid[i + 1];
      end
      held_valid[PendDepth - 1] = 1'b0;
   endfunction

   function automatic result_word_type tracker_predict(request_word_type w);
      result_word_type r;
      int slot;
      int hit;
      int i;
      slot = -1;
      hit = -1;
      r.trigger = 1'b0;
      r.outcome = OUT_NO_MATCH;
      case (w.mode)
         MODE_INSERT: begin
            for (i = 0; i < PendDepth; i++)
               if (slot < 0 && !held_valid[i])
                  slot = i;
            if (slot < 0) begin
               r.outcome = OUT_FULL;
            end else begin
               held_entry[slot] = '{address: w.source_address, port: w.dest_port,
                                    ident: w.ident, requested: w.requested_lifetime,
                                    remaining: w.remaining_lifetime};
               held_valid[slot] = 1'b1;
               r.outcome = OUT_INSERTED;
            end
         end
         MODE_REPLY: begin
            for (i = 0; i < PendDepth; i++)
               if (hit < 0 && held_valid[i] && held_entry[i].address == w.source_address
                   && held_entry[i].port == w.dest_port)
                  hit = i;
            if (hit < 0) begin
               r.outcome = OUT_NO_MATCH;
            end else if (ones_sum(w) != 16'hFFFF && w.checksum_field != 16'd0) begin
               drop_entry(hit);
               r.outcome = OUT_BAD_CSUM;
            end else if (held_entry[hit].ident != w.ident) begin
               r.outcome = OUT_ID_MISS;
            end else if (w.reply_code <= CodeAcceptMax) begin
               if (w.source_address != home_cfg) begin
                  link_up_now = 1'b1;
                  agent_now = held_entry[hit].address;
                  life_now = held_entry[hit].remaining
                             - (held_entry[hit].requested - w.granted_lifetime);
                  timer_running = 1'b1;
                  r.outcome = OUT_FOREIGN;
               end else begin
                  timer_running = 1'b0;
                  r.outcome = OUT_HOME;
               end
               drop_entry(hit);
            end else begin
               drop_entry(hit);
               r.outcome = OUT_DENIED;
            end
         end
         MODE_TICK: begin
            r.outcome = OUT_TICK;
            if (timer_running && life_now != 16'd0) begin
               life_now = life_now - 16'd1;
               r.trigger = (life_now == threshold_cfg);
               if (life_now == 16'd0)
                  link_up_now = 1'b0;
            end
         end
         default: r.outcome = OUT_NO_MATCH;
      endcase
      r.connected = link_up_now;
      r.agent = agent_now;
      r.life = life_now;
      return r;
   endfunction

   function automatic request_word_type random_word(mode_type mode);
      request_word_type w;
      w.mode = mode;
      w.source_address = $urandom;
      w.dest_address = $urandom;
      w.dest_port = 16'($urandom);
      w.udp_length = 16'($urandom_range(65535, 8));
      w.segment_checksum = 16'($urandom);
      w.checksum_field = 16'($urandom);
      w.ident = $urandom;
      w.reply_code = 8'($urandom);
      w.granted_lifetime = 16'($urandom);
      w.requested_lifetime = 16'($urandom);
      w.remaining_lifetime = 16'($urandom);
      return w;
   endfunction

   function automatic request_word_type insert_word(logic [31:0] address, logic [15:0] port,
         logic [31:0] ident, logic [15:0] requested, logic [15:0] remaining);
      request_word_type w;
      w = random_word(MODE_INSERT);
      w.source_address = address;
      w.dest_port = port;
      w.ident = ident;
      w.requested_lifetime = requested;
      w.remaining_lifetime = remaining;
      return w;
   endfunction

   function automatic request_word_type reply_word(logic [31:0] address, logic [15:0] port,
         logic [31:0] ident, logic [7:0] code, logic [15:0] granted, bit good,
         logic [15:0] csum_field);
      request_word_type w;
      logic [15:0] sum;
      w = random_word(MODE_REPLY);
      w.source_address = address;
      w.dest_port = port;
      w.ident = ident;
      w.reply_code = code;
      w.granted_lifetime = granted;
      w.checksum_field = csum_field;
      w.segment_checksum = 16'hFFFF;
      sum = ones_sum(w);
      w.segment_checksum = good ? sum : sum ^ 16'($urandom_range(65535, 1));
      return w;
   endfunction

   // keeps a rough copy of the table so that replies can be aimed at live entries
   function automatic void enqueue(request_word_type w);
      int h;
      int i;
      h = -1;
      if (w.mode == MODE_INSERT) begin
         if (booked_requests.size() < PendDepth)
            booked_requests.push_back('{address: w.source_address, port: w.dest_port,
                                        ident: w.ident, requested: w.requested_lifetime,
                                        remaining: w.remaining_lifetime});
      end else if (w.mode == MODE_REPLY) begin
         for (i = 0; i < booked_requests.size(); i++)
            if (h < 0 && booked_requests[i].address == w.source_address
                && booked_requests[i].port == w.dest_port)
               h = i;
         if (h >= 0 && ((ones_sum(w) != 16'hFFFF && w.checksum_field != 16'd0)
                        || booked_requests[h].ident == w.ident))
            booked_requests.delete(h);
      end
      request_backlog.push_back(w);
   endfunction

   function automatic request_word_type random_request();
      request_word_type w;
      entry_type e;
      int pick;
      int span;
      logic [31:0] address;
      logic [15:0] port;
      logic [15:0] granted;
      pick = $urandom_range(99);
      if (pick >= 30 && pick < 65 && booked_requests.size() != 0) begin
         e = booked_requests[$urandom_range(booked_requests.size() - 1)];
         span = (e.remaining < e.requested) ? int'(e.remaining) : int'(e.requested);
         if ($urandom_range(99) < 75)
            granted = e.requested - 16'($urandom_range(span));
         else
            granted = 16'($urandom);
         w = reply_word(e.address, e.port,
                        ($urandom_range(99) < 85) ? e.ident : $urandom,
                        ($urandom_range(99) < 70) ? 8'($urandom_range(1))
                                                  : 8'($urandom_range(255, 2)),
                        granted, $urandom_range(99) < 85,
                        ($urandom_range(99) < 10) ? 16'd0 : 16'($urandom_range(65535, 1)));
      end else if (pick < 65) begin
         pick = $urandom_range(99);
         if (pick < 10)
            address = home_cfg;
         else if (pick < 30)
            address = 32'h0A00_0000 + $urandom_range(3);
         else
            address = $urandom;
         port = ($urandom_range(99) < 40) ? 16'($urandom_range(434, 432)) : 16'($urandom);
         w = insert_word(address, port, $urandom,
                         ($urandom_range(99) < 85) ? 16'($urandom_range(40)) : 16'($urandom),
                         ($urandom_range(99) < 85) ? 16'($urandom_range(12)) : 16'($urandom));
      end else if (pick < 92) begin
         w = random_word(MODE_TICK);
      end else if (pick < 96) begin
         w = random_word(MODE_REPLY);
      end else begin
         w = random_word(MODE_UNUSED);
      end
      return w;
   endfunction

   task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
      mismatch_count++;
      $display("%0t: result word %0d %s got %0h expected %0h", $time, replies_checked,
               field, got, want);
   endtask

   task automatic check_reply();
      result_word_type want;
      replies_checked++;
      if (expected_results.size() == 0) begin
         flag_mismatch("arrived with nothing pending, outcome", 32'(rsp_outcome), 32'd0);
         return;
      end
      want = expected_results.pop_front();
      if (rsp_outcome !== want.outcome)
         flag_mismatch("outcome", 32'(rsp_outcome), 32'(want.outcome));
      if (rsp_connected !== want.connected)
         flag_mismatch("connected", 32'(rsp_connected), 32'(want.connected));
      if (rsp_foreign_agent !== want.agent)
         flag_mismatch("foreign_agent", rsp_foreign_agent, want.agent);
      if (rsp_lifetime_left !== want.life)
         flag_mismatch("lifetime_left", 32'(rsp_lifetime_left), 32'(want.life));
      if (rsp_rereg_trigger !== want.trigger)
         flag_mismatch("rereg_trigger", 32'(rsp_rereg_trigger), 32'(want.trigger));
      outcome_seen[want.outcome]++;
      if (want.trigger)
         trigger_seen++;
   endtask

   // monitor: result words first, then the request word taken at this edge
   always @(posedge clock) begin
      if (reset) begin
         in_fire = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            check_reply();
         in_fire = req_valid && req_ready;
         if (in_fire) begin
            expected_results.push_back(tracker_predict(drive_word));
            requests_taken++;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || in_fire) begin
         if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            drive_word = request_backlog.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock)
      rsp_ready <= !reset && !long_hold_on && ($urandom_range(99) >= stall_pct);

   // long receiver hold-off so the block backs up into its input
   initial begin
      wait (long_hold_go);
      @(posedge clock);
      long_hold_on = 1'b1;
      repeat (90) @(posedge clock);
      long_hold_on = 1'b0;
   end

   task automatic wait_quiet();
      do
         @(posedge clock);
      while (request_backlog.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic program_regs(logic [31:0] home, logic [15:0] threshold);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CsrHomeAgent;
      csr_write_data <= home;
      @(negedge clock);
      csr_index <= CsrThreshold;
      csr_write_data <= {16'd0, threshold};
      @(negedge clock);
      csr_write_enable <= 1'b0;
      home_cfg = home;
      threshold_cfg = threshold;
   endtask

   task automatic run_phase(int idx, int count);
      int n;
      send_idle_pct = (idx % 4 == 1) ? 65 : (idx % 4 == 3) ? 36 : 0;
      stall_pct = (idx % 4 == 2) ? 65 : (idx % 4 == 3) ? 36 : 0;
      for (n = 0; n < count; n++) begin
         if (n == count / 2) begin
            wait_quiet();
            if (idx == 4)
               long_hold_go = 1'b1;
         end
         enqueue(random_request());
      end
      wait_quiet();
   endtask

   initial begin
      int p;
      int k;
      logic [31:0] home;
      home = 32'hC0A8_0001;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      program_regs(home, ThresholdReset);

      // directed: idle tick, unused mode, empty table, fill and overflow
      enqueue(random_word(MODE_TICK));
      enqueue(random_word(MODE_UNUSED));
      enqueue(reply_word(32'h5, 16'h5, 32'd0, 8'd0, 16'd0, 1'b1, 16'h0001));
      enqueue(insert_word(32'd0, 16'd0, 32'd0, 16'd0, 16'd0));
      enqueue(insert_word(home, 16'd434, 32'd1, 16'd100, 16'd100));
      enqueue(insert_word(32'h0A00_0002, 16'd434, 32'd2, 16'd100, 16'd100));
      enqueue(insert_word(32'h0A00_0003, 16'd434, 32'd3, 16'd100, 16'd100));
      enqueue(insert_word(32'h0A00_0004, 16'd434, 32'd4, 16'd10, 16'd7));
      enqueue(insert_word(32'h0A00_0003, 16'd435, 32'd5, 16'd100, 16'd100));
      enqueue(insert_word(32'h0A00_0003, 16'd434, 32'd6, 16'd100, 16'd100));
      enqueue(insert_word(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
      enqueue(insert_word(32'h0A00_0009, 16'd9, 32'd9, 16'd1, 16'd1));
      // bad checksum, ident miss on the older duplicate, ignored checksum with denial
      enqueue(reply_word(32'h0A00_0002, 16'd434, 32'd2, 8'd0, 16'd0, 1'b0, 16'hFFFF));
      enqueue(reply_word(32'h0A00_0003, 16'd434, 32'd6, 8'd0, 16'd0, 1'b1, 16'h0001));
      enqueue(reply_word(32'h0A00_0003, 16'd434, 32'd3, 8'd255, 16'd0, 1'b0, 16'd0));
      // home accept, then foreign accept with lifetime 5 counted down to zero and held
      enqueue(reply_word(home, 16'd434, 32'd1, 8'd1, 16'd50, 1'b1, 16'h8000));
      enqueue(reply_word(32'h0A00_0004, 16'd434, 32'd4, 8'd0, 16'd8, 1'b1, 16'hFFFF));
      for (k = 0; k < 6; k++)
         enqueue(random_word(MODE_TICK));
      enqueue(reply_word(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'd0, 16'd0, 1'b1,
                         16'h1234));
      wait_quiet();

      for (p = 0; p < 8; p++) begin
         case (p)
            0: program_regs(32'h0000_0000, 16'd0);
            1: program_regs(32'hFFFF_FFFF, 16'hFFFF);
            2: program_regs($urandom, ThresholdReset);
            3: program_regs($urandom, 16'($urandom_range(8, 1)));
            5: program_regs(32'h0000_0000, ThresholdReset);
            6: program_regs(32'hFFFF_FFFF, 16'd0);
            default: program_regs($urandom, 16'($urandom_range(10)));
         endcase
         run_phase(p, 240);
      end

      repeat (10) @(posedge clock);
      $display("covered %0d request words in nine register settings and four idle mixes,",
               requests_taken);
      $display("%0d results: outcomes 0..8 = %0d %0d %0d %0d %0d %0d %0d %0d %0d, %0d rereg",
               replies_checked, outcome_seen[0], outcome_seen[1], outcome_seen[2],
               outcome_seen[3], outcome_seen[4], outcome_seen[5], outcome_seen[6],
               outcome_seen[7], outcome_seen[8], trigger_seen);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/rrt_pkg.sv
hw/rtl/rrt_cell.sv
hw/rtl/rrt_csum.sv
hw/rtl/registration_reply_tracker_unit.sv
hw/rtl/rrt_checker.sv
tb/tb.sv
